FILE: design/fwir_pkg.sv
// Shared types, widths and codes for the queue with positional insert and remove-matching.
`timescale 1ns / 1ps
package fwir_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int WORD_WIDTH  = 64;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the stream payloads
  localparam int ACTION_W  = 3;
  localparam int VALUE_W   = 64;
  localparam int POS_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_FIELDS_W  = ACTION_W + VALUE_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + OUT_CNT_W + OUT_CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Action codes on the input stream
  localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [WORD_WIDTH-1:0] word;
    logic [POS_W-1:0]      pos;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [VALUE_W-1:0]   popped;
    logic [OUT_CNT_W-1:0] count;
    logic [OUT_CNT_W-1:0] removed;
  } res_t;

endpackage

FILE: design/fwir_cmd_queue.sv
// Front end: accept input transfers, decode the action and buffer commands in a two-slot queue.
`timescale 1ns / 1ps
module fwir_cmd_queue
  import fwir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic [ACTION_W-1:0] action;
  cmd_t                dec;
  cmd_t                slot_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push, pull;

  assign action = in_tdata[ACTION_W-1:0];

  // Classify the action; unused codes become no-ops
  always_comb begin
    dec.word = in_tdata[ACTION_W +: WORD_WIDTH];
    dec.pos  = in_tdata[ACTION_W+VALUE_W +: POS_W];
    unique case (action)
      ACT_PUSH:   dec.op = OP_PUSH;
      ACT_POP:    dec.op = OP_POP;
      ACT_INSERT: dec.op = OP_INSERT;
      ACT_REMOVE: dec.op = OP_REMOVE;
      ACT_CLEAR:  dec.op = OP_CLEAR;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_tvalid & in_tready;
  assign pull      = cmd_valid & cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pull ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pull};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: design/fwir_engine.sv
// Back end: entry memory, occupancy and the sequencer that shifts or compacts entries.
`timescale 1ns / 1ps
module fwir_engine
  import fwir_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } state_t;

  logic [WORD_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [WORD_WIDTH-1:0] mem_wd;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  op_t                   mode_r, mode_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]      ins_addr_r, ins_addr_nxt;
  logic [CNT_W-1:0]      left_r, left_nxt;
  logic [IDX_W-1:0]      ri_r, ri_nxt;
  logic [CNT_W-1:0]      wi_r, wi_nxt;
  logic                  vld_r, vld_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      removed_r, removed_nxt;
  logic [WORD_WIDTH-1:0] popped_r, popped_nxt;
  logic                  out_vld_r, out_vld_nxt;
  res_t                  res_r, res_nxt;

  logic [CMP_W-1:0]      pos_e, occ_e;
  logic                  full, empty, drop;

  assign cmd_ready = (state_r == S_IDLE) && !out_vld_r;
  assign res_valid = out_vld_r;
  assign res       = res_r;

  assign pos_e = CMP_W'(cmd.pos);
  assign occ_e = CMP_W'(occ_r);
  assign full  = (occ_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (occ_r == '0);
  assign drop  = (mode_r == OP_POP) ? (idx_r == '0) : (rd_data_r == key_r);

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    ins_addr_nxt = ins_addr_r;
    left_nxt     = left_r;
    ri_nxt       = ri_r;
    wi_nxt       = wi_r;
    vld_nxt      = 1'b0;
    idx_nxt      = idx_r;
    removed_nxt  = removed_r;
    popped_nxt   = popped_r;
    out_vld_nxt  = out_vld_r & ~res_ready;
    res_nxt      = res_r;
    rd_addr      = ri_r;
    mem_we       = 1'b0;
    mem_wa       = IDX_W'(wi_r);
    mem_wd       = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          res_nxt.status  = ST_OK;
          res_nxt.popped  = '0;
          res_nxt.removed = '0;
          mode_nxt        = cmd.op;
          key_nxt         = cmd.word;
          ins_addr_nxt    = IDX_W'(pos_e - CMP_W'(1));
          removed_nxt     = '0;
          popped_nxt      = '0;
          wi_nxt          = '0;
          ri_nxt          = '0;
          left_nxt        = occ_r;
          out_vld_nxt     = 1'b1;
          unique case (cmd.op)
            OP_PUSH: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = IDX_W'(occ_r);
                mem_wd  = cmd.word;
                occ_nxt = occ_r + CNT_W'(1);
              end
            end
            OP_POP, OP_REMOVE: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                out_vld_nxt = 1'b0;
                state_nxt   = S_RUN;
              end
            end
            OP_INSERT: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else if (pos_e == '0 || pos_e > occ_e) begin
                res_nxt.status = ST_BADPOS;
              end else if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                // Move the tail end up one slot, last entry first
                left_nxt    = CNT_W'(occ_e - pos_e + CMP_W'(1));
                ri_nxt      = IDX_W'(occ_r - CNT_W'(1));
                out_vld_nxt = 1'b0;
                state_nxt   = S_RUN;
              end
            end
            OP_CLEAR: begin
              res_nxt.removed = OUT_CNT_W'(occ_r);
              occ_nxt         = '0;
            end
            default: ;
          endcase
          res_nxt.count = OUT_CNT_W'(occ_nxt);
        end
      end

      S_RUN: begin
        // Issue one read a cycle; data comes back the next cycle
        if (left_r != '0) begin
          left_nxt = left_r - CNT_W'(1);
          ri_nxt   = (mode_r == OP_INSERT) ? ri_r - IDX_W'(1) : ri_r + IDX_W'(1);
          vld_nxt  = 1'b1;
          idx_nxt  = ri_r;
        end

        if (vld_r) begin
          if (mode_r == OP_INSERT) begin
            mem_we = 1'b1;
            mem_wa = idx_r + IDX_W'(1);
          end else if (drop) begin
            if (mode_r == OP_POP) begin
              popped_nxt = rd_data_r;
            end else begin
              removed_nxt = removed_r + CNT_W'(1);
            end
          end else begin
            mem_we = 1'b1;
            wi_nxt = wi_r + CNT_W'(1);
          end
        end

        if (left_r == '0 && !vld_r) begin
          res_nxt.status  = ST_OK;
          res_nxt.popped  = VALUE_W'(popped_r);
          res_nxt.removed = OUT_CNT_W'(removed_r);
          if (mode_r == OP_INSERT) begin
            mem_we  = 1'b1;
            mem_wa  = ins_addr_r;
            mem_wd  = key_r;
            occ_nxt = occ_r + CNT_W'(1);
          end else begin
            occ_nxt = wi_r;
          end
          res_nxt.count = OUT_CNT_W'(occ_nxt);
          out_vld_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      out_vld_r <= 1'b0;
      vld_r     <= 1'b0;
      left_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      out_vld_r <= out_vld_nxt;
      vld_r     <= vld_nxt;
      left_r    <= left_nxt;
    end
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    ins_addr_r <= ins_addr_nxt;
    ri_r       <= ri_nxt;
    wi_r       <= wi_nxt;
    idx_r      <= idx_nxt;
    removed_r  <= removed_nxt;
    popped_r   <= popped_nxt;
    res_r      <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

FILE: design/fifo_with_insert_and_remove_matching_core.sv
// Top level: FIFO of words with positional insert and remove-matching over stream channels.
//
//   channel | dir | handshake         | payload
//   in_     | in  | in_tvalid/tready  | action, value, position
//   out_    | out | out_tvalid/tready | status, popped_value, entry_count, removed_count
//
// Push, clear, unused actions and rejected operations: the engine takes the command and
// presents the result the next cycle. Pop and remove-matching pass over every entry in between,
// insert over the entries from the position to the tail and then writes the new word, paced by
// the single read port and single write port of the entry memory: one entry moves a cycle.
// The engine takes its next command the cycle after the result transfer; the command queue
// registers each input transfer before offering it to the engine.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
// A two-slot command queue holds up to two commands while the engine works or a result is stalled.
`timescale 1ns / 1ps
module fifo_with_insert_and_remove_matching_core
  import fwir_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // action[2:0], value[66:3], position[71:67]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status[1:0], popped_value[65:2],
                                             // entry_count[70:66], removed_count[75:71]
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  fwir_cmd_queue u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fwir_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = OUT_TDATA_W'({res.removed, res.count, res.popped, res.status});

endmodule

FILE: test/fifo_with_insert_and_remove_matching_core_test.sv
// Self-checking stream testbench for the queue with positional insert and remove-matching.
`timescale 1ns / 1ps
module fifo_with_insert_and_remove_matching_core_test;
  import fwir_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_PCT     = 32;

  // Action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX  = {POS_W{1'b1}};

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    pos;
    int                  reps;
    bit                  typed;
    res_t                want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the queue contents
  logic [WORD_WIDTH-1:0] shadow_words [QUEUE_DEPTH];
  int                    shadow_fill;

  res_t      awaited_results [$];
  stim_row_t stim_rows [$];
  logic [VALUE_W-1:0] key_pool [4];
  int  errors;
  int  cycle_count;
  bit  steady_stretch;
  bit  fill_phase;

  fifo_with_insert_and_remove_matching_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one operation to the shadow queue and return the result it yields
  function automatic res_t apply_queue_op(input logic [ACTION_W-1:0] act,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [POS_W-1:0] pos);
    res_t                  r;
    logic [WORD_WIDTH-1:0] word;
    int                    kept;
    int                    dropped;
    r       = '0;
    r.status = ST_OK;
    word    = value[WORD_WIDTH-1:0];
    dropped = 0;
    case (act)
      ACT_PUSH: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = VALUE_W'(shadow_words[0]);
          for (int i = 1; i < shadow_fill; i++) shadow_words[i-1] = shadow_words[i];
          shadow_fill--;
        end
      end
      ACT_INSERT: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) < 1 || int'(pos) > shadow_fill) begin
          r.status = ST_BADPOS;
        end else if (shadow_fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_fill; i >= int'(pos); i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[int'(pos)-1] = word;
          shadow_fill++;
        end
      end
      ACT_REMOVE: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          kept = 0;
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_words[i] == word) begin
              dropped++;
            end else begin
              shadow_words[kept] = shadow_words[i];
              kept++;
            end
          end
          shadow_fill = kept;
        end
      end
      ACT_CLEAR: begin
        dropped     = shadow_fill;
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    r.count   = OUT_CNT_W'(shadow_fill);
    r.removed = OUT_CNT_W'(dropped);
    return r;
  endfunction

  // Present one item, hold it until the transfer, then record what it should produce
  task automatic drive_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] pos, input bit typed, input res_t want);
    res_t predicted;
    while (!steady_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({pos, value, act});
    do @(posedge clk); while (!in_tready);
    predicted = apply_queue_op(act, value, pos);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Hold off the input side until every outstanding result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic add_row(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] value,
                         input logic [POS_W-1:0] pos, input int reps, input bit typed,
                         input logic [STATUS_W-1:0] status, input logic [VALUE_W-1:0] popped,
                         input int count, input int removed);
    stim_row_t row;
    row.act          = act;
    row.value        = value;
    row.pos          = pos;
    row.reps         = reps;
    row.typed        = typed;
    row.want.status  = status;
    row.want.popped  = popped;
    row.want.count   = OUT_CNT_W'(count);
    row.want.removed = OUT_CNT_W'(removed);
    stim_rows.push_back(row);
  endtask

  task automatic pick_random_item(output logic [ACTION_W-1:0] act,
                                  output logic [VALUE_W-1:0] value,
                                  output logic [POS_W-1:0] pos);
    int roll;
    int pos_roll;
    roll = $urandom_range(99);
    // Alternate between growing and shrinking the queue so both full and empty are reached
    if (fill_phase) begin
      if (roll < 40) act = ACT_PUSH;
      else if (roll < 70) act = ACT_INSERT;
      else if (roll < 82) act = ACT_POP;
      else if (roll < 94) act = ACT_REMOVE;
      else if (roll < 97) act = ACT_CLEAR;
      else act = ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    end else begin
      if (roll < 15) act = ACT_PUSH;
      else if (roll < 27) act = ACT_INSERT;
      else if (roll < 65) act = ACT_POP;
      else if (roll < 92) act = ACT_REMOVE;
      else if (roll < 97) act = ACT_CLEAR;
      else act = ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    end

    if (act == ACT_REMOVE && shadow_fill > 0 && $urandom_range(1) == 1) begin
      value = VALUE_W'(shadow_words[$urandom_range(shadow_fill - 1, 0)]);
    end else if ($urandom_range(99) < 60) begin
      value = key_pool[$urandom_range(3)];
    end else begin
      value = {$urandom, $urandom};
    end

    pos_roll = $urandom_range(99);
    if (pos_roll < 70) pos = POS_W'($urandom_range(shadow_fill > 0 ? shadow_fill : 1, 1));
    else if (pos_roll < 80) pos = POS_W'(shadow_fill + 1);
    else if (pos_roll < 90) pos = '0;
    else pos = POS_W'($urandom_range(POS_MAX));
  endtask

  // Result side: check each transfer against the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no expected result: tdata %h", out_tdata);
          errors++;
        end else begin
          res_t want;
          res_t got;
          want        = awaited_results.pop_front();
          got.status  = out_tdata[STATUS_W-1:0];
          got.popped  = out_tdata[STATUS_W +: VALUE_W];
          got.count   = out_tdata[STATUS_W + VALUE_W +: OUT_CNT_W];
          got.removed = out_tdata[STATUS_W + VALUE_W + OUT_CNT_W +: OUT_CNT_W];
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.popped !== want.popped) begin
            $error("popped_value mismatch: expected %h, actual %h", want.popped, got.popped);
            errors++;
          end
          if (got.count !== want.count) begin
            $error("entry_count mismatch: expected %0d, actual %0d", want.count, got.count);
            errors++;
          end
          if (got.removed !== want.removed) begin
            $error("removed_count mismatch: expected %0d, actual %0d",
                   want.removed, got.removed);
            errors++;
          end
        end
      end
      out_tready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fifo_with_insert_and_remove_matching_core");
      $finish;
    end
  end

  initial begin
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    pos;
    res_t                none;
    stim_row_t           row;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    errors         = 0;
    cycle_count    = 0;
    steady_stretch = 1'b0;
    fill_phase     = 1'b1;
    shadow_fill    = 0;
    none           = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) shadow_words[i] = '0;
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    key_pool[2] = {$urandom, $urandom};
    key_pool[3] = {$urandom, $urandom};

    // Empty queue: every operation that needs an entry is refused
    add_row(ACT_POP,        '0,       5'd0, 1, 1, ST_EMPTY, '0, 0, 0);
    add_row(ACT_INSERT,     64'd1,    5'd1, 1, 1, ST_EMPTY, '0, 0, 0);
    add_row(ACT_REMOVE,     '0,       5'd0, 1, 1, ST_EMPTY, '0, 0, 0);
    add_row(ACT_CLEAR,      '0,       5'd0, 1, 1, ST_OK,    '0, 0, 0);
    add_row(ACT_SPARE_LAST, ALL_ONES, POS_MAX, 1, 1, ST_OK, '0, 0, 0);
    add_row(ACT_PUSH,       ALL_ONES, 5'd0, 1, 1, ST_OK,    '0, 1, 0);
    add_row(ACT_PUSH,       '0,       5'd0, 1, 1, ST_OK,    '0, 2, 0);
    // Insert position zero and one past the tail
    add_row(ACT_INSERT,     64'd9,    5'd0, 1, 1, ST_BADPOS, '0, 2, 0);
    add_row(ACT_INSERT,     64'd9,    5'd3, 1, 1, ST_BADPOS, '0, 2, 0);
    add_row(ACT_INSERT,     64'd5,    5'd1, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_INSERT,     64'd7,    5'd3, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_POP,        '0,       5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_SPARE_FIRST, 64'd3,   5'd2, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_PUSH,       64'ha5a5_a5a5_a5a5_a5a5, 5'd0, QUEUE_DEPTH - 3, 0,
            ST_OK, '0, 0, 0);
    // Full queue: push and a valid insert are refused, a bad position wins over full
    add_row(ACT_PUSH,       64'd1,    5'd0, 1, 1, ST_FULL,   '0, QUEUE_DEPTH, 0);
    add_row(ACT_INSERT,     64'd2,    5'd1, 1, 1, ST_FULL,   '0, QUEUE_DEPTH, 0);
    add_row(ACT_INSERT,     64'd2,    5'd17, 1, 1, ST_BADPOS, '0, QUEUE_DEPTH, 0);
    add_row(ACT_INSERT,     64'd2,    POS_MAX, 1, 1, ST_BADPOS, '0, QUEUE_DEPTH, 0);
    add_row(ACT_REMOVE,     64'ha5a5_a5a5_a5a5_a5a5, 5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_REMOVE,     64'h1234, 5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_POP,        '0,       5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_PUSH,       64'd7,    5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_REMOVE,     64'd7,    5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_CLEAR,      '0,       5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_PUSH,       ALL_ONES, 5'd0, 1, 0, ST_OK, '0, 0, 0);
    add_row(ACT_POP,        '0,       5'd0, 1, 0, ST_OK, '0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      for (int k = 0; k < row.reps; k++) drive_item(row.act, row.value, row.pos, row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) fill_phase = ~fill_phase;
      if (n == 600) steady_stretch = 1'b1;
      if (n == 800) steady_stretch = 1'b0;
      if (n == 400 || n == 900) drain_results();
      pick_random_item(act, value, pos);
      drive_item(act, value, pos, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fifo_with_insert_and_remove_matching_core");
    end else begin
      $display("FAIL fifo_with_insert_and_remove_matching_core");
    end
    $finish;
  end

endmodule
